// ===== design/scti_pkg.sv =====
package scti_pkg;

    // Default bit split of the phase word
    localparam int PHASE_BITS = 32;
    localparam int INDEX_BITS_DEF = 8;
    localparam int FRACTION_BITS_DEF = 22;
    localparam int OUTPUT_FRACTION_BITS_DEF = 16;
    localparam int OUT_WIDTH = 18;

    // pi/2 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Taylor series sine in Q30, evaluated at elaboration only
    function automatic logic signed [63:0] sine_q30(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        begin
            x2   = (x * x) >> 30;
            term = x;
            sum  = $signed(x);
            term = ((term * x2) >> 30) / 64'd6;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd20;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd42;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd72;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd110;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd156;
            sum  = sum + $signed(term);
            term = ((term * x2) >> 30) / 64'd210;
            sum  = sum - $signed(term);
            term = ((term * x2) >> 30) / 64'd272;
            sum  = sum + $signed(term);
            return sum;
        end
    endfunction

    // Quarter-wave table entry k, rounded to ofb fraction bits
    function automatic logic [63:0] rom_value(input int k, input int ib, input int ofb);
        logic [63:0]        x;
        logic signed [63:0] v;
        int                 sh;
        begin
            sh = 30 - ofb;
            x  = (HALF_PI_Q30 * 64'(k)) >> ib;
            v  = sine_q30(x);
            if (v < 0)
            begin
                v = '0;
            end
            return (64'(v) + (64'd1 << (sh - 1))) >> sh;
        end
    endfunction

endpackage

// ===== design/scti_rom.sv =====
module scti_rom
    import scti_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int OUTPUT_FRACTION_BITS = OUTPUT_FRACTION_BITS_DEF
)
(
    input  logic [INDEX_BITS-1:0]         index,
    output logic [OUTPUT_FRACTION_BITS:0] sin_lo,
    output logic [OUTPUT_FRACTION_BITS:0] sin_hi,
    output logic [OUTPUT_FRACTION_BITS:0] cos_lo,
    output logic [OUTPUT_FRACTION_BITS:0] cos_hi
);

    localparam int STEPS = 1 << INDEX_BITS;
    localparam int EW = OUTPUT_FRACTION_BITS + 1;

    // constant quarter-wave sine table, STEPS+1 entries
    logic [EW-1:0] rom_tbl [STEPS+1];

    for (genvar k = 0; k <= STEPS; k++)
    begin : g_rom
        assign rom_tbl[k] = EW'(rom_value(k, INDEX_BITS, OUTPUT_FRACTION_BITS));
    end

    // forward and mirrored addresses
    logic [INDEX_BITS:0] idx_ext;
    logic [INDEX_BITS:0] idx_next;
    logic [INDEX_BITS:0] idx_mirror;
    logic [INDEX_BITS:0] idx_mirror_m1;

    assign idx_ext       = {1'b0, index};
    assign idx_next      = idx_ext + 1'b1;
    assign idx_mirror    = (INDEX_BITS+1)'(STEPS) - idx_ext;
    assign idx_mirror_m1 = {1'b0, ~index};

    assign sin_lo = rom_tbl[idx_ext];
    assign sin_hi = rom_tbl[idx_next];
    assign cos_lo = rom_tbl[idx_mirror];
    assign cos_hi = rom_tbl[idx_mirror_m1];

endmodule

// ===== design/sine_cosine_table_interpolator.sv =====
// Sine/cosine by quarter-wave table lookup with linear interpolation.
// Register stages from input to output beat: table read, multiply, and
// shift/add with quadrant map. Throughput: one beat per cycle while the
// output is not stalled; a stall holds full stages, empty ones still fill.
// Reset (rst_n, async, active low) empties the pipe; the table is constant.
module sine_cosine_table_interpolator
    import scti_pkg::*;
#(
    parameter int INDEX_BITS = INDEX_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int OUTPUT_FRACTION_BITS = OUTPUT_FRACTION_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [PHASE_BITS-1:0]       phase,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [OUT_WIDTH-1:0] sine_value,
    output logic signed [OUT_WIDTH-1:0] cosine_value
);

    localparam int EW = OUTPUT_FRACTION_BITS + 1;   // table entry width
    localparam int DW = EW + 1;                     // difference width
    localparam int PW = FRACTION_BITS + DW + 1;     // product width
    localparam int VW = EW + 2;                     // interpolated value width
    localparam int XW = PHASE_BITS + 8;             // phase, zero-extended
    localparam int QL = INDEX_BITS + FRACTION_BITS; // quadrant lsb

    // stage enables: a stage moves when its successor is empty or moves
    logic en1, en2, en3;
    logic v1_reg, v2_reg, v3_reg;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    // phase split
    logic [XW-1:0]            phase_ext;
    logic [FRACTION_BITS-1:0] frac;
    logic [INDEX_BITS-1:0]    index;
    logic [1:0]               quad;

    assign phase_ext = {8'd0, phase};
    assign frac      = phase_ext[FRACTION_BITS-1:0];
    assign index     = phase_ext[FRACTION_BITS +: INDEX_BITS];
    assign quad      = phase_ext[QL +: 2];

    logic [EW-1:0] sin_lo, sin_hi, cos_lo, cos_hi;

    scti_rom #(
        .INDEX_BITS           (INDEX_BITS),
        .OUTPUT_FRACTION_BITS (OUTPUT_FRACTION_BITS)
    ) u_rom (
        .index  (index),
        .sin_lo (sin_lo),
        .sin_hi (sin_hi),
        .cos_lo (cos_lo),
        .cos_hi (cos_hi)
    );

    // stage 1: table entries
    logic [EW-1:0]            s_a1_reg, s_b1_reg, c_a1_reg, c_b1_reg;
    logic [FRACTION_BITS-1:0] f1_reg;
    logic [1:0]               q1_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s_a1_reg <= sin_lo;
            s_b1_reg <= sin_hi;
            c_a1_reg <= cos_lo;
            c_b1_reg <= cos_hi;
            f1_reg   <= frac;
            q1_reg   <= quad;
        end
    end

    // stage 2: f * (b - a)
    logic signed [DW-1:0] s_diff, c_diff;
    logic signed [PW-1:0] s_prod_next, c_prod_next;
    logic signed [PW-1:0] s_prod2_reg, c_prod2_reg;
    logic [EW-1:0]        s_a2_reg, c_a2_reg;
    logic [1:0]           q2_reg;

    assign s_diff      = $signed({1'b0, s_b1_reg}) - $signed({1'b0, s_a1_reg});
    assign c_diff      = $signed({1'b0, c_b1_reg}) - $signed({1'b0, c_a1_reg});
    assign s_prod_next = $signed({1'b0, f1_reg}) * s_diff;
    assign c_prod_next = $signed({1'b0, f1_reg}) * c_diff;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s_prod2_reg <= s_prod_next;
            c_prod2_reg <= c_prod_next;
            s_a2_reg    <= s_a1_reg;
            c_a2_reg    <= c_a1_reg;
            q2_reg      <= q1_reg;
        end
    end

    // stage 3: floor shift, add base, quadrant map
    logic signed [PW-1:0] s_q, c_q;
    logic signed [VW-1:0] s_val, c_val;
    logic signed [VW-1:0] sv_next, cv_next;
    logic signed [OUT_WIDTH-1:0] sine3_reg, cosine3_reg;

    assign s_q   = s_prod2_reg >>> FRACTION_BITS;
    assign c_q   = c_prod2_reg >>> FRACTION_BITS;
    assign s_val = $signed({2'b00, s_a2_reg}) + VW'(s_q);
    assign c_val = $signed({2'b00, c_a2_reg}) + VW'(c_q);

    always_comb
    begin
        case (q2_reg)
            QUAD_0:
            begin
                sv_next = s_val;
                cv_next = c_val;
            end
            QUAD_1:
            begin
                sv_next = c_val;
                cv_next = -s_val;
            end
            QUAD_2:
            begin
                sv_next = -s_val;
                cv_next = -c_val;
            end
            default:
            begin
                sv_next = -c_val;
                cv_next = s_val;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            sine3_reg   <= OUT_WIDTH'(sv_next);
            cosine3_reg <= OUT_WIDTH'(cv_next);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    assign out_valid    = v3_reg;
    assign sine_value   = sine3_reg;
    assign cosine_value = cosine3_reg;

endmodule

// ===== design/scti_checker.sv =====
module scti_checker
    import scti_pkg::*;
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic signed [OUT_WIDTH-1:0] sine_value,
    input logic signed [OUT_WIDTH-1:0] cosine_value
);

    localparam logic signed [OUT_WIDTH-1:0] ONE = OUT_WIDTH'(1 << OUTPUT_FRACTION_BITS_DEF);

    // a stalled output beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(sine_value) && $stable(cosine_value))
        else $error("output payload changed while stalled");

    // with no output beat waiting the pipe always takes input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid || !in_valid) && !out_valid |-> in_ready)
        else $error("input stalled while output is empty");

    // results stay within unit range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sine_value <= ONE && sine_value >= -ONE
                   && cosine_value <= ONE && cosine_value >= -ONE)
        else $error("result outside unit range");

    // sine and cosine never vanish together
    a_not_both_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sine_value != '0 || cosine_value != '0)
        else $error("sine and cosine both zero");

endmodule

bind sine_cosine_table_interpolator scti_checker u_scti_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sine_value   (sine_value),
    .cosine_value (cosine_value)
);
